// ----- src/hkrd_pkg.sv -----
// Shared types, constants and usage tables of the HID keyboard report decoder.
package hkrd_pkg;

   localparam int KEY_SLOTS           = 6;
   localparam int PRESS_QUEUE_DEPTH   = 2;
   localparam int RESULT_QUEUE_DEPTH  = 2;

   localparam logic [7:0] SHIFT_MASK  = 8'h22;

   localparam logic [7:0] USAGE_A     = 8'h04;
   localparam logic [7:0] USAGE_Z     = 8'h1D;
   localparam logic [7:0] USAGE_ONE   = 8'h1E;
   localparam logic [7:0] USAGE_SLASH = 8'h38;
   localparam logic [7:0] USAGE_CAPS  = 8'h39;
   localparam logic [7:0] USAGE_F1    = 8'h3A;
   localparam logic [7:0] USAGE_F12   = 8'h45;
   localparam logic [7:0] USAGE_RIGHT = 8'h4F;
   localparam logic [7:0] USAGE_UP    = 8'h52;

   localparam logic [6:0] ASCII_LOWER_A = 7'h61;
   localparam logic [6:0] ASCII_UPPER_A = 7'h41;

   localparam int SYM_COUNT = 27;

   localparam logic [6:0] SYM_LO [SYM_COUNT] = '{
      7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
      7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C,
      7'h2E, 7'h2F
   };

   localparam logic [6:0] SYM_HI [SYM_COUNT] = '{
      7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
      7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C,
      7'h3E, 7'h3F
   };

   typedef enum logic [1:0] {
      CSR_ENABLED          = 2'd0,
      CSR_SPECIAL_KEY_BASE = 2'd1,
      CSR_REPEAT_DELAY     = 2'd2,
      CSR_REPEAT_RATE      = 2'd3
   } csr_index_type;

   typedef logic [7:0] usage_type;
   typedef usage_type [KEY_SLOTS-1:0] slots_type;

   typedef struct packed {
      logic        enabled;
      logic [15:0] special_key_base;
      logic [15:0] repeat_delay;
      logic [15:0] repeat_rate;
   } cfg_type;

   typedef struct packed {
      logic                 shift;
      slots_type            slots;
      logic [KEY_SLOTS-1:0] fresh;
      logic [31:0]          now;
   } press_type;

   typedef struct packed {
      logic [6:0]  char_code;
      logic [15:0] key_code;
      logic        caps_state;
   } result_type;

   function automatic logic [6:0] usage_char(usage_type u, logic shift, logic caps);
      logic [6:0] c;
      logic [4:0] idx;
      c   = '0;
      idx = '0;
      if (u inside {[USAGE_A:USAGE_Z]}) begin
         c = ((shift ^ caps) ? ASCII_UPPER_A : ASCII_LOWER_A) + 7'(u - USAGE_A);
      end else if (u inside {[USAGE_ONE:USAGE_SLASH]}) begin
         idx = 5'(u - USAGE_ONE);
         c   = shift ? SYM_HI[idx] : SYM_LO[idx];
      end
      return c;
   endfunction

   function automatic logic fn_or_arrow_key(usage_type u);
      return u inside {[USAGE_F1:USAGE_F12], [USAGE_RIGHT:USAGE_UP]};
   endfunction

endpackage

// ----- src/hkrd_fifo.sv -----
// Small first-in first-out queue with push/full and pop/empty sides.
module hkrd_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = hkrd_pkg::PRESS_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_en;
   logic             rd_en;

   function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr_en = push & ~full;
   assign rd_en = pop & ~empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> (count_ff == $past(count_ff)) && (wr_ptr_ff == $past(wr_ptr_ff)))
      else $error("queue written while full");

endmodule

// ----- src/hkrd_front.sv -----
// Front end: takes polls, tracks the previous report and marks fresh key slots.
module hkrd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enabled,
   input  logic                          req_push,
   input  logic                          req_action,
   input  logic [7:0]                    req_modifier_bits,
   input  hkrd_pkg::slots_type           req_slots,
   input  logic [31:0]                   req_now_tick,
   input  logic                          press_full,
   output logic                          press_push,
   output hkrd_pkg::press_type           press_entry
);

   import hkrd_pkg::*;

   slots_type  prior_slots_ff, prior_slots_in;
   logic [7:0] prior_mod_ff, prior_mod_in;
   logic       take;

   assign take       = req_push & ~press_full & enabled;
   assign press_push = take;

   always_comb begin
      logic seen;
      prior_slots_in = prior_slots_ff;
      prior_mod_in   = prior_mod_ff;
      if (req_action) begin
         prior_slots_in = req_slots;
         prior_mod_in   = req_modifier_bits;
      end
      press_entry.slots = prior_slots_in;
      press_entry.shift = |(prior_mod_in & SHIFT_MASK);
      press_entry.now   = req_now_tick;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         seen = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            seen = seen | (prior_slots_ff[j] == req_slots[i]);
         end
         press_entry.fresh[i] = req_action & (req_slots[i] != '0) & ~seen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_slots_ff <= '0;
         prior_mod_ff   <= '0;
      end else if (take) begin
         prior_slots_ff <= prior_slots_in;
         prior_mod_ff   <= prior_mod_in;
      end
   end

endmodule

// ----- src/hkrd_back.sv -----
// Back end: applies presses, caps lock and typematic repeat, and forms results.
module hkrd_back (
   input  logic                clock,
   input  logic                reset,
   input  hkrd_pkg::cfg_type   cfg,
   input  hkrd_pkg::press_type press_entry,
   input  logic                press_empty,
   output logic                press_pop,
   input  logic                result_full,
   output logic                result_push,
   output hkrd_pkg::result_type result_entry
);

   import hkrd_pkg::*;

   logic        caps_ff, caps_in;
   usage_type   held_ff, held_in;
   logic [31:0] since_ff, since_in;
   logic [31:0] last_ff, last_in;
   logic        run;

   assign run         = ~press_empty & ~result_full;
   assign press_pop   = run;
   assign result_push = run;

   always_comb begin
      usage_type   u;
      usage_type   key_u;
      logic        key_hit;
      logic [6:0]  ch;
      logic [6:0]  c;
      logic        pressed;
      logic        present;
      logic        repeat_now;
      logic [31:0] since_d;
      logic [31:0] last_d;
      logic [15:0] neg_base;

      neg_base = 16'd0 - cfg.special_key_base;
      caps_in  = caps_ff;
      held_in  = held_ff;
      ch       = '0;
      key_u    = '0;
      key_hit  = 1'b0;
      pressed  = 1'b0;

      for (int i = 0; i < KEY_SLOTS; i++) begin
         u = press_entry.slots[i];
         if (press_entry.fresh[i]) begin
            if (u == USAGE_CAPS) begin
               caps_in = ~caps_in;
            end else begin
               c = usage_char(u, press_entry.shift, caps_in);
               if (c != '0) begin
                  ch = c;
               end else if (fn_or_arrow_key(u) && ({8'h00, u} != neg_base)) begin
                  key_u   = u;
                  key_hit = 1'b1;
               end
               held_in = u;
               pressed = 1'b1;
            end
         end
      end

      present = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         present = present | (press_entry.slots[i] == held_in);
      end

      since_d = pressed ? '0 : press_entry.now - since_ff;
      last_d  = pressed ? '0 : press_entry.now - last_ff;

      repeat_now = (held_in != '0) && present &&
                   (since_d >= {16'h0000, cfg.repeat_delay}) &&
                   (last_d >= {16'h0000, cfg.repeat_rate});

      if ((held_in != '0) && !present) begin
         held_in = '0;
      end

      c = usage_char(held_in, press_entry.shift, caps_in);
      if (repeat_now) begin
         if (c != '0) begin
            ch = c;
         end else if (fn_or_arrow_key(held_in) && ({8'h00, held_in} != neg_base)) begin
            key_u   = held_in;
            key_hit = 1'b1;
         end
      end

      since_in = pressed ? press_entry.now : since_ff;
      last_in  = (pressed || repeat_now) ? press_entry.now : last_ff;

      result_entry.char_code  = ch;
      result_entry.key_code   = key_hit ? cfg.special_key_base + {8'h00, key_u} : '0;
      result_entry.caps_state = caps_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         caps_ff  <= 1'b0;
         held_ff  <= '0;
         since_ff <= '0;
         last_ff  <= '0;
      end else if (run) begin
         caps_ff  <= caps_in;
         held_ff  <= held_in;
         since_ff <= since_in;
         last_ff  <= last_in;
      end
   end

   a_held_not_caps: assert property (@(posedge clock) disable iff (reset)
      held_ff != USAGE_CAPS)
      else $error("caps lock recorded as held key");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !run |=> (caps_ff == $past(caps_ff)) && (held_ff == $past(held_ff)))
      else $error("state moved without a transfer");

   a_caps_needs_press: assert property (@(posedge clock) disable iff (reset)
      (run && (press_entry.fresh == '0)) |=> caps_ff == $past(caps_ff))
      else $error("caps lock toggled without a fresh key");

   a_key_zero_no_char: assert property (@(posedge clock) disable iff (reset)
      (run && (result_entry.key_code != '0)) |-> (result_entry.key_code
         != cfg.special_key_base))
      else $error("special key formed from an empty usage");

endmodule

// ----- src/hid_keyboard_report_decoder_core.sv -----
// Top level of the HID boot-keyboard report decoder with typematic repeat.
//
//   Channel  Handshake          Transfer when     Payload
//   req      req_push/req_full  push & !full      action, modifiers, slots, tick
//   rsp      rsp_empty/rsp_pop  pop & !empty      char, key code, caps state
//   csr      csr_we             csr_we            index, 16-bit data
//
// One poll per cycle sustained while rsp_pop drains results. The rate is set by the
// combinational back stage: slot decode plus the two repeat timer compares. Reset
// (synchronous) restores register defaults and clears all state. With rsp_pop low,
// two results fill the result queue, two more polls fill the press queue, and
// req_full rises. Polls taken while disabled are dropped and give no result.
module hid_keyboard_report_decoder_core #(
   parameter int PRESS_DEPTH  = hkrd_pkg::PRESS_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = hkrd_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [7:0]  req_modifier_bits,
   input  logic [7:0]  req_slot_0,
   input  logic [7:0]  req_slot_1,
   input  logic [7:0]  req_slot_2,
   input  logic [7:0]  req_slot_3,
   input  logic [7:0]  req_slot_4,
   input  logic [7:0]  req_slot_5,
   input  logic [31:0] req_now_tick,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_char_code,
   output logic [15:0] rsp_key_code,
   output logic        rsp_caps_state,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import hkrd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   slots_type  req_slots;
   press_type  press_in;
   press_type  press_out;
   logic       press_push;
   logic       press_full;
   logic       press_empty;
   logic       press_pop;
   result_type result_in;
   result_type result_out;
   logic       result_push;
   logic       result_full;

   assign req_slots = {req_slot_5, req_slot_4, req_slot_3,
                       req_slot_2, req_slot_1, req_slot_0};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLED:          cfg_in.enabled          = csr_wdata[0];
            CSR_SPECIAL_KEY_BASE: cfg_in.special_key_base = csr_wdata;
            CSR_REPEAT_DELAY:     cfg_in.repeat_delay     = csr_wdata;
            CSR_REPEAT_RATE:      cfg_in.repeat_rate      = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled          <= 1'b0;
         cfg_ff.special_key_base <= 16'd256;
         cfg_ff.repeat_delay     <= 16'd50;
         cfg_ff.repeat_rate      <= 16'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hkrd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .enabled           (cfg_ff.enabled),
      .req_push          (req_push),
      .req_action        (req_action),
      .req_modifier_bits (req_modifier_bits),
      .req_slots         (req_slots),
      .req_now_tick      (req_now_tick),
      .press_full        (press_full),
      .press_push        (press_push),
      .press_entry       (press_in)
   );

   assign req_full = press_full;

   hkrd_fifo #(
      .WIDTH ($bits(press_type)),
      .DEPTH (PRESS_DEPTH)
   ) u_press_queue (
      .clock (clock),
      .reset (reset),
      .push  (press_push),
      .wdata (press_in),
      .full  (press_full),
      .pop   (press_pop),
      .rdata (press_out),
      .empty (press_empty)
   );

   hkrd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .press_entry  (press_out),
      .press_empty  (press_empty),
      .press_pop    (press_pop),
      .result_full  (result_full),
      .result_push  (result_push),
      .result_entry (result_in)
   );

   hkrd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (result_push),
      .wdata (result_in),
      .full  (result_full),
      .pop   (rsp_pop),
      .rdata (result_out),
      .empty (rsp_empty)
   );

   assign rsp_char_code  = result_out.char_code;
   assign rsp_key_code   = result_out.key_code;
   assign rsp_caps_state = result_out.caps_state;

endmodule

// ----- tb/hkrd_decode_monitor.sv -----
// Channel monitor, result predictor and comparator for the HID keyboard report decoder.
`timescale 1ns / 100ps

module hkrd_decode_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_action,
   input  logic [7:0]  req_modifier_bits,
   input  logic [7:0]  req_slot_0,
   input  logic [7:0]  req_slot_1,
   input  logic [7:0]  req_slot_2,
   input  logic [7:0]  req_slot_3,
   input  logic [7:0]  req_slot_4,
   input  logic [7:0]  req_slot_5,
   input  logic [31:0] req_now_tick,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [6:0]  rsp_char_code,
   input  logic [15:0] rsp_key_code,
   input  logic        rsp_caps_state,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          outstanding
);

   import hkrd_pkg::*;

   localparam int MAX_REPORTS = 10;

   localparam logic [6:0] PLAIN_SYMS [27] = '{
      7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
      7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C, 7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C,
      7'h2E, 7'h2F
   };

   localparam logic [6:0] SHIFTED_SYMS [27] = '{
      7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20,
      7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C, 7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C,
      7'h3E, 7'h3F
   };

   logic        dev_ready;
   logic [15:0] key_base;
   logic [15:0] hold_delay;
   logic [15:0] repeat_gap;

   slots_type   last_slots;
   logic [7:0]  last_mods;
   logic        caps_on;
   usage_type   typed_key;
   logic [31:0] typed_at;
   logic [31:0] repeated_at;

   result_type  expected_results [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic translate_usage(input usage_type u, input logic shift,
                                  inout logic [6:0] ch, inout logic [15:0] key);
      logic [6:0]  c;
      logic [15:0] k;
      c = '0;
      k = key_base + 16'(u);
      if (u >= USAGE_A && u <= USAGE_Z)
         c = ((shift ^ caps_on) ? ASCII_UPPER_A : ASCII_LOWER_A) + 7'(u - USAGE_A);
      else if (u >= USAGE_ONE && u <= USAGE_SLASH)
         c = shift ? SHIFTED_SYMS[int'(u - USAGE_ONE)] : PLAIN_SYMS[int'(u - USAGE_ONE)];
      if (c != 0)
         ch = c;
      else if (((u >= USAGE_F1 && u <= USAGE_F12) || (u >= USAGE_RIGHT && u <= USAGE_UP))
               && k != 0)
         key = k;
   endtask

   task automatic decode_poll(input logic act, input logic [7:0] mods,
                              input slots_type keys, input logic [31:0] tick);
      slots_type   earlier;
      logic        shift;
      logic        fresh;
      logic        still_down;
      logic [6:0]  ch;
      logic [15:0] key;
      result_type  r;
      ch  = '0;
      key = '0;
      if (!dev_ready)
         return;
      if (act) begin
         earlier    = last_slots;
         last_mods  = mods;
         last_slots = keys;
         shift      = (mods & SHIFT_MASK) != 0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            fresh = keys[i] != 0;
            for (int j = 0; j < KEY_SLOTS; j++)
               if (earlier[j] == keys[i])
                  fresh = 1'b0;
            if (fresh && keys[i] == USAGE_CAPS) begin
               caps_on = !caps_on;
            end else if (fresh) begin
               translate_usage(keys[i], shift, ch, key);
               typed_key   = keys[i];
               typed_at    = tick;
               repeated_at = tick;
            end
         end
      end
      if (typed_key != 0) begin
         still_down = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++)
            if (last_slots[j] == typed_key)
               still_down = 1'b1;
         if (!still_down) begin
            typed_key = '0;
         end else if ((tick - typed_at) >= 32'(hold_delay) &&
                      (tick - repeated_at) >= 32'(repeat_gap)) begin
            repeated_at = tick;
            translate_usage(typed_key, (last_mods & SHIFT_MASK) != 0, ch, key);
         end
      end
      r.char_code  = ch;
      r.key_code   = key;
      r.caps_state = caps_on;
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         dev_ready   = 1'b0;
         key_base    = 16'd256;
         hold_delay  = 16'd50;
         repeat_gap  = 16'd5;
         last_slots  = '0;
         last_mods   = '0;
         caps_on     = 1'b0;
         typed_key   = '0;
         typed_at    = '0;
         repeated_at = '0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ENABLED:          dev_ready  = csr_wdata[0];
               CSR_SPECIAL_KEY_BASE: key_base   = csr_wdata;
               CSR_REPEAT_DELAY:     hold_delay = csr_wdata;
               CSR_REPEAT_RATE:      repeat_gap = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result with nothing expected: char %02h key %04h caps %0d",
                           $realtime, rsp_char_code, rsp_key_code, rsp_caps_state);
            end else begin
               want = expected_results.pop_front();
               if (want.char_code !== rsp_char_code || want.key_code !== rsp_key_code ||
                   want.caps_state !== rsp_caps_state) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: expected char %02h key %04h caps %0d, got char %02h key %04h caps %0d",
                              $realtime, want.char_code, want.key_code, want.caps_state,
                              rsp_char_code, rsp_key_code, rsp_caps_state);
               end
            end
         end
         if (req_push && !req_full)
            decode_poll(req_action, req_modifier_bits,
                        {req_slot_5, req_slot_4, req_slot_3, req_slot_2, req_slot_1, req_slot_0},
                        req_now_tick);
      end
      outstanding = expected_results.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// Stimulus, clock, reset and verdict for the HID keyboard report decoder core.
`timescale 1ns / 100ps

module tb_top;
   import hkrd_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_action;
   logic [7:0]  req_modifier_bits;
   logic [7:0]  req_slot_0;
   logic [7:0]  req_slot_1;
   logic [7:0]  req_slot_2;
   logic [7:0]  req_slot_3;
   logic [7:0]  req_slot_4;
   logic [7:0]  req_slot_5;
   logic [31:0] req_now_tick;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [6:0]  rsp_char_code;
   logic [15:0] rsp_key_code;
   logic        rsp_caps_state;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int          mismatches;
   int          outstanding;

   logic        steady = 1'b0;
   int          pop_stall = 0;
   slots_type   board;
   logic [7:0]  mods_now;
   logic [31:0] tick_now;

   always #6 clock = ~clock;

   hid_keyboard_report_decoder_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_action        (req_action),
      .req_modifier_bits (req_modifier_bits),
      .req_slot_0        (req_slot_0),
      .req_slot_1        (req_slot_1),
      .req_slot_2        (req_slot_2),
      .req_slot_3        (req_slot_3),
      .req_slot_4        (req_slot_4),
      .req_slot_5        (req_slot_5),
      .req_now_tick      (req_now_tick),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_char_code     (rsp_char_code),
      .rsp_key_code      (rsp_key_code),
      .rsp_caps_state    (rsp_caps_state),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   hkrd_decode_monitor scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_action        (req_action),
      .req_modifier_bits (req_modifier_bits),
      .req_slot_0        (req_slot_0),
      .req_slot_1        (req_slot_1),
      .req_slot_2        (req_slot_2),
      .req_slot_3        (req_slot_3),
      .req_slot_4        (req_slot_4),
      .req_slot_5        (req_slot_5),
      .req_now_tick      (req_now_tick),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_char_code     (rsp_char_code),
      .rsp_key_code      (rsp_key_code),
      .rsp_caps_state    (rsp_caps_state),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic usage_type pick_usage();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return usage_type'($urandom_range(USAGE_A, USAGE_Z));
      else if (r < 65)
         return usage_type'($urandom_range(USAGE_ONE, USAGE_SLASH));
      else if (r < 72)
         return USAGE_CAPS;
      else if (r < 80)
         return usage_type'($urandom_range(USAGE_F1, USAGE_F12));
      else if (r < 87)
         return usage_type'($urandom_range(USAGE_RIGHT, USAGE_UP));
      else
         return usage_type'($urandom_range(0, 255));
   endfunction

   // stall the result side at random
   always @(negedge clock) begin
      if (pop_stall > 0) begin
         rsp_pop <= 1'b0;
         pop_stall--;
      end else begin
         rsp_pop <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            pop_stall = pick_gap();
      end
   end

   task automatic send_poll(input logic act, input logic [7:0] mods,
                            input slots_type keys, input logic [31:0] tick);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push          <= 1'b1;
      req_action        <= act;
      req_modifier_bits <= mods;
      req_slot_0        <= keys[0];
      req_slot_1        <= keys[1];
      req_slot_2        <= keys[2];
      req_slot_3        <= keys[3];
      req_slot_4        <= keys[4];
      req_slot_5        <= keys[5];
      req_now_tick      <= tick;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
   endtask

   // poll without a report; the report fields carry noise
   task automatic send_idle_poll(input logic [31:0] tick);
      send_poll(1'b0, 8'($urandom), {$urandom, 16'($urandom)}, tick);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_registers(input logic en, input logic [15:0] base,
                                input logic [15:0] delay, input logic [15:0] rate);
      logic [15:0] values [4];
      values = '{16'(en), base, delay, rate};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= values[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_poll(input int step_max);
      int r;
      int k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, KEY_SLOTS - 1);
      tick_now += $urandom_range(0, step_max);
      if (r < 10) begin
         send_poll(1'($urandom), 8'($urandom), {$urandom, 16'($urandom)}, tick_now);
      end else if (r < 35) begin
         send_idle_poll(tick_now);
      end else begin
         if (r < 62)
            board[k] = pick_usage();
         else if (r < 85)
            board[k] = '0;
         else if (r < 92)
            mods_now = 8'($urandom);
         else
            mods_now ^= SHIFT_MASK & 8'($urandom);
         send_poll(1'b1, mods_now, board, tick_now);
      end
   endtask

   task automatic random_phase(input int count, input int step_max);
      board    = '0;
      mods_now = '0;
      tick_now = $urandom;
      repeat (count) random_poll(step_max);
      drain();
   endtask

   initial begin
      reset             = 1'b1;
      req_push          = 1'b0;
      req_action        = 1'b0;
      req_modifier_bits = '0;
      req_slot_0        = '0;
      req_slot_1        = '0;
      req_slot_2        = '0;
      req_slot_3        = '0;
      req_slot_4        = '0;
      req_slot_5        = '0;
      req_now_tick      = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_ENABLED;
      csr_wdata         = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled after reset: polls are dropped
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_00_04, 32'd5);
      send_idle_poll(32'd90);
      drain();

      set_registers(1'b1, 16'd256, 16'd50, 16'd5);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_00_04, 32'd100);
      send_poll(1'b1, 8'h02, 48'h00_00_00_00_1E_1D, 32'd101);
      send_poll(1'b1, 8'h20, 48'h00_00_00_00_04_39, 32'd102);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_04_05, 32'd103);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_52_3A, 32'd104);
      send_idle_poll(32'd150);
      send_idle_poll(32'd154);
      send_idle_poll(32'd158);
      send_idle_poll(32'd159);
      send_poll(1'b1, 8'h00, 48'h52_FF_53_46_01_32, 32'd160);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_05_05, 32'd161);
      send_poll(1'b1, 8'hFF, 48'hFF_FF_FF_FF_FF_FF, 32'd162);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_00_00, 32'd163);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_00_39, 32'd164);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_00_28, 32'hFFFF_FFF0);
      send_idle_poll(32'h0000_0022);
      send_poll(1'b1, 8'h22, 48'h00_00_00_00_28_2D, 32'h0000_0023);
      send_idle_poll(32'hFFFF_FFFF);
      drain();

      // key code wrapping to zero, repeat on the press itself
      set_registers(1'b1, 16'hFFC6, 16'd0, 16'd0);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_3B_3A, 32'd10);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_3B_04, 32'd11);
      send_idle_poll(32'd11);
      drain();

      set_registers(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_poll(1'b1, 8'h00, 48'h00_00_00_00_00_50, 32'd0);
      send_idle_poll(32'd65534);
      send_idle_poll(32'd65535);
      drain();

      set_registers(1'b1, 16'($urandom), 16'($urandom_range(3, 12)),
                    16'($urandom_range(1, 4)));
      random_phase(200, 3);
      set_registers(1'b1, 16'hFFC6, 16'd0, 16'd0);
      random_phase(150, 2);
      set_registers(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(100, 40000);
      set_registers(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(30, 5);
      set_registers(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(120, 70000);
      steady = 1'b1;
      set_registers(1'b1, 16'd0, 16'd2, 16'd1);
      random_phase(180, 2);
      steady = 1'b0;

      if (mismatches == 0 && outstanding == 0)
         $display("** hid_keyboard_report_decoder_core: PASSED **");
      else
         $display("** hid_keyboard_report_decoder_core: FAILED **");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** hid_keyboard_report_decoder_core: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/hkrd_pkg.sv
src/hkrd_fifo.sv
src/hkrd_front.sv
src/hkrd_back.sv
src/hid_keyboard_report_decoder_core.sv
tb/hkrd_decode_monitor.sv
tb/tb_top.sv
